FILE: rtl/wcsr_pkg.sv
package wcsr_pkg;

    // Configuration register file, one field per register
    typedef struct packed {
        logic [7:0]         line_width;
        logic               thick_mode;
        logic               current_mode;
        logic signed [15:0] level_gain;
        logic [15:0]        zero_row;
        logic [12:0]        graph_height;
        logic [12:0]        graph_width;
    } cfg_t;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THICK_MODE   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CURRENT_MODE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_GAIN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_ROW     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRAPH_HEIGHT = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRAPH_WIDTH  = 3'd6;

    // Register reset values
    localparam logic [7:0]  RST_LINE_WIDTH   = 8'd16;
    localparam logic        RST_THICK_MODE   = 1'b1;
    localparam logic        RST_CURRENT_MODE = 1'b0;
    localparam logic [15:0] RST_LEVEL_GAIN   = 16'hFF00;
    localparam logic [15:0] RST_ZERO_ROW     = 16'h8000;
    localparam logic [12:0] RST_GRAPH_HEIGHT = 13'd480;
    localparam logic [12:0] RST_GRAPH_WIDTH  = 13'd640;

    // Arithmetic constants
    localparam int GAIN_FRACTION_BITS = 8;      // level_gain is Q8.8
    localparam int SQRT2M1_Q16        = 27146;  // sqrt(2) - 1 in Q0.16
    localparam int SLOPE_LIMIT        = 5;      // rows, at and above it the width grows linearly

    // Front-to-back job queue
    localparam int QUEUE_DEPTH_LOG2 = 2;

endpackage

FILE: rtl/wcsr_sample_if.sv
interface wcsr_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] level_sample;
    logic                          start_graph;

    modport source (output valid, output level_sample, output start_graph, input ready);
    modport sink   (input valid, input level_sample, input start_graph, output ready);
endinterface

FILE: rtl/wcsr_span_if.sv
interface wcsr_span_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row_low;
    logic [COORD_BITS-1:0] row_high;
    logic                  colour;
    logic                  span_empty;

    modport source (output valid, output column, output row_low, output row_high,
                    output colour, output span_empty, input ready);
    modport sink   (input valid, input column, input row_low, input row_high,
                    input colour, input span_empty, output ready);
endinterface

FILE: rtl/wcsr_front.sv
module wcsr_front #(
    parameter int ROW_FRACTION_BITS = 4,
    parameter int COORD_BITS        = 12,
    parameter int SAMPLE_BITS       = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wcsr_pkg::cfg_t       cfg,
    wcsr_sample_if.sink          samples,
    output logic                 q_push,
    output logic [COORD_BITS+3*(COORD_BITS+ROW_FRACTION_BITS+2):0] q_job,
    input  logic                 q_full
);
    import wcsr_pkg::*;

    localparam int ROW_BITS   = COORD_BITS + ROW_FRACTION_BITS + 2;
    localparam int PROD_BITS  = SAMPLE_BITS + 16;
    localparam int SUM_BITS   = PROD_BITS + 1;
    localparam int SHIFT      = GAIN_FRACTION_BITS - ROW_FRACTION_BITS;
    localparam int COUNT_BITS = COORD_BITS + 1;
    localparam int WBITS      = (COUNT_BITS > 13) ? COUNT_BITS : 13;

    // Input stage: sample and its scaled level
    logic                          f1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] level_reg;
    logic                          start_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;

    // Window and counters
    logic signed [SAMPLE_BITS-1:0] older_level_reg, centre_level_reg;
    logic signed [ROW_BITS-1:0]    older_row_reg, centre_row_reg;
    logic [COUNT_BITS-1:0]         column_count_reg;
    logic [1:0]                    prime_count_reg;

    logic signed [PROD_BITS-1:0] prod_shift;
    logic signed [SUM_BITS-1:0]  row_sum;
    logic signed [ROW_BITS-1:0]  row;
    logic [1:0]                  prime;
    logic [COUNT_BITS-1:0]       count;
    logic [WBITS-1:0]            width_ext, width_lim, width_cap;
    logic                        priming, emit, colour, go, accept;

    // Row mapping with saturation to the row range
    always_comb
    begin
        prod_shift = prod_reg >>> SHIFT;
        row_sum = $signed({prod_shift[PROD_BITS-1], prod_shift})
                + $signed({{(SUM_BITS-16){1'b0}}, cfg.zero_row});
        if ((&row_sum[SUM_BITS-1:ROW_BITS-1]) || !(|row_sum[SUM_BITS-1:ROW_BITS-1]))
        begin
            row = row_sum[ROW_BITS-1:0];
        end
        else if (row_sum[SUM_BITS-1])
        begin
            row = $signed({1'b1, {(ROW_BITS-1){1'b0}}});
        end
        else
        begin
            row = $signed({1'b0, {(ROW_BITS-1){1'b1}}});
        end
    end

    // Classify: prime, emit or drop
    always_comb
    begin
        prime     = start_reg ? 2'd0 : prime_count_reg;
        count     = start_reg ? '0 : column_count_reg;
        width_ext = WBITS'(cfg.graph_width);
        width_lim = WBITS'(1) << COORD_BITS;
        width_cap = (width_ext > width_lim) ? width_lim : width_ext;
        priming   = !prime[1];
        emit      = !priming && (WBITS'(count) < width_cap);
        if (cfg.current_mode)
        begin
            colour = !(centre_level_reg > 0);
        end
        else
        begin
            colour = !(older_level_reg < centre_level_reg);
        end
    end

    assign go            = f1_valid_reg && (!emit || !q_full);
    assign q_push        = go && emit;
    assign samples.ready = !f1_valid_reg || go;
    assign accept        = samples.valid && samples.ready;
    assign q_job         = {colour, count[COORD_BITS-1:0], older_row_reg, centre_row_reg, row};

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f1_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            f1_valid_reg <= 1'b0;
        end
    end

    // Input stage payload, gain multiply
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg <= samples.level_sample;
            start_reg <= samples.start_graph;
            prod_reg  <= samples.level_sample * cfg.level_gain;
        end
    end

    // Window shift and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_level_reg  <= '0;
            centre_level_reg <= '0;
            older_row_reg    <= '0;
            centre_row_reg   <= '0;
            column_count_reg <= '0;
            prime_count_reg  <= '0;
        end
        else if (go && (priming || emit))
        begin
            older_level_reg  <= centre_level_reg;
            centre_level_reg <= level_reg;
            older_row_reg    <= centre_row_reg;
            centre_row_reg   <= row;
            if (priming)
            begin
                prime_count_reg  <= prime + 2'd1;
                column_count_reg <= count;
            end
            else
            begin
                column_count_reg <= count + COUNT_BITS'(1);
            end
        end
    end

endmodule

FILE: rtl/wcsr_queue.sv
module wcsr_queue #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]      entry_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [DEPTH_LOG2:0]   count_reg;
    logic                  do_push, do_pop;

    assign full    = (count_reg == (DEPTH_LOG2+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + DEPTH_LOG2'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + DEPTH_LOG2'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (DEPTH_LOG2+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (DEPTH_LOG2+1)'(1);
            end
        end
    end

endmodule

FILE: rtl/wcsr_back.sv
module wcsr_back #(
    parameter int ROW_FRACTION_BITS = 4,
    parameter int COORD_BITS        = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  wcsr_pkg::cfg_t cfg,
    input  logic           q_empty,
    input  logic [COORD_BITS+3*(COORD_BITS+ROW_FRACTION_BITS+2):0] q_job,
    output logic           q_pop,
    wcsr_span_if.source    spans
);
    import wcsr_pkg::*;

    localparam int RFB      = ROW_FRACTION_BITS;
    localparam int ROW_BITS = COORD_BITS + RFB + 2;
    localparam int SLW_BITS = 4 + RFB;
    localparam int F_BITS   = 18 + RFB;
    localparam int MUL_BITS = SLW_BITS + F_BITS;
    localparam int D_BITS   = ROW_BITS + 1;
    localparam int HW_BITS  = D_BITS + 1;
    localparam int YW_A     = (ROW_BITS + 3 > 14 + RFB) ? ROW_BITS + 3 : 14 + RFB;
    localparam int YW       = (YW_A > 17) ? YW_A : 17;
    localparam int PIX_BITS = YW - RFB + 1;
    localparam int SMALL_BITS = RFB + 3;

    // Job fields
    logic signed [ROW_BITS-1:0] j_older, j_centre, j_new;
    logic [COORD_BITS-1:0]      j_column;
    logic                       j_colour;

    assign j_new    = q_job[ROW_BITS-1:0];
    assign j_centre = q_job[2*ROW_BITS-1:ROW_BITS];
    assign j_older  = q_job[3*ROW_BITS-1:2*ROW_BITS];
    assign j_column = q_job[3*ROW_BITS+COORD_BITS-1:3*ROW_BITS];
    assign j_colour = q_job[3*ROW_BITS+COORD_BITS];

    // Whole pipeline moves when the output slot frees up
    logic adv;
    assign adv   = !spans.valid || spans.ready;
    assign q_pop = adv && !q_empty;

    // Line width in row units
    logic [8+RFB-1:0]    slw_full;
    logic [SLW_BITS-1:0] slw;
    assign slw_full = {cfg.line_width, {RFB{1'b0}}};
    assign slw      = slw_full[8+RFB-1:4];

    // ---------------- stage 1: slopes and slope factors ----------------
    logic signed [D_BITS-1:0] dy_l, dy_r;
    logic [D_BITS-1:0]        ady_l, ady_r;
    logic [F_BITS-1:0]        f_l, f_r;

    always_comb
    begin
        dy_l  = $signed({j_centre[ROW_BITS-1], j_centre}) - $signed({j_older[ROW_BITS-1], j_older});
        dy_r  = $signed({j_centre[ROW_BITS-1], j_centre}) - $signed({j_new[ROW_BITS-1], j_new});
        ady_l = dy_l[D_BITS-1] ? D_BITS'(-dy_l) : D_BITS'(dy_l);
        ady_r = dy_r[D_BITS-1] ? D_BITS'(-dy_r) : D_BITS'(dy_r);
        f_l   = (F_BITS'(1) << (16 + RFB))
              + F_BITS'(SQRT2M1_Q16) * F_BITS'(ady_l[SMALL_BITS-1:0]);
        f_r   = (F_BITS'(1) << (16 + RFB))
              + F_BITS'(SQRT2M1_Q16) * F_BITS'(ady_r[SMALL_BITS-1:0]);
    end

    logic                       b1_valid_reg;
    logic signed [ROW_BITS-1:0] b1_centre_reg;
    logic [COORD_BITS-1:0]      b1_column_reg;
    logic                       b1_colour_reg;
    logic                       b1_neg_l_reg, b1_neg_r_reg, b1_small_l_reg, b1_small_r_reg;
    logic [D_BITS-1:0]          b1_ady_l_reg, b1_ady_r_reg;
    logic [F_BITS-1:0]          b1_f_l_reg, b1_f_r_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_centre_reg  <= j_centre;
            b1_column_reg  <= j_column;
            b1_colour_reg  <= j_colour;
            b1_neg_l_reg   <= dy_l[D_BITS-1];
            b1_neg_r_reg   <= dy_r[D_BITS-1];
            b1_small_l_reg <= ady_l < D_BITS'(SLOPE_LIMIT << RFB);
            b1_small_r_reg <= ady_r < D_BITS'(SLOPE_LIMIT << RFB);
            b1_ady_l_reg   <= ady_l;
            b1_ady_r_reg   <= ady_r;
            b1_f_l_reg     <= f_l;
            b1_f_r_reg     <= f_r;
        end
    end

    // ---------------- stage 2: half widths ----------------
    logic [MUL_BITS-1:0]       mul_l, mul_r, mul_sh_l, mul_sh_r;
    logic [D_BITS:0]           lin_l, lin_r;
    logic [D_BITS-1:0]         lw_l, lw_r;
    logic signed [HW_BITS-1:0] hw_l, hw_r;

    always_comb
    begin
        mul_l    = MUL_BITS'(slw) * MUL_BITS'(b1_f_l_reg);
        mul_r    = MUL_BITS'(slw) * MUL_BITS'(b1_f_r_reg);
        mul_sh_l = mul_l >> (17 + RFB);
        mul_sh_r = mul_r >> (17 + RFB);
        lin_l    = (D_BITS+1)'(b1_ady_l_reg) + (D_BITS+1)'(slw);
        lin_r    = (D_BITS+1)'(b1_ady_r_reg) + (D_BITS+1)'(slw);
        lw_l     = b1_small_l_reg ? D_BITS'(mul_sh_l) : lin_l[D_BITS:1];
        lw_r     = b1_small_r_reg ? D_BITS'(mul_sh_r) : lin_r[D_BITS:1];
        hw_l     = b1_neg_l_reg ? -$signed({1'b0, lw_l}) : $signed({1'b0, lw_l});
        hw_r     = b1_neg_r_reg ? -$signed({1'b0, lw_r}) : $signed({1'b0, lw_r});
    end

    logic                       b2_valid_reg;
    logic signed [ROW_BITS-1:0] b2_centre_reg;
    logic [COORD_BITS-1:0]      b2_column_reg;
    logic                       b2_colour_reg;
    logic signed [HW_BITS-1:0]  b2_hw_l_reg, b2_hw_r_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b2_centre_reg <= b1_centre_reg;
            b2_column_reg <= b1_column_reg;
            b2_colour_reg <= b1_colour_reg;
            b2_hw_l_reg   <= hw_l;
            b2_hw_r_reg   <= hw_r;
        end
    end

    // ---------------- stage 3: span ends in row units ----------------
    logic signed [YW-1:0] c_ext, yl, yr, half_slw, fill_a, ya, yb;

    always_comb
    begin
        c_ext    = YW'(b2_centre_reg);
        half_slw = $signed(YW'(slw >> 1));
        yl       = c_ext - YW'(b2_hw_l_reg);
        yr       = c_ext - YW'(b2_hw_r_reg);
        // peak and trough fixes
        if (c_ext > yl && c_ext > yr)
        begin
            if (yl > yr)
            begin
                yl = c_ext + half_slw;
            end
            else
            begin
                yr = c_ext + half_slw;
            end
        end
        else if (c_ext < yl && c_ext < yr)
        begin
            if (yl < yr)
            begin
                yl = c_ext - half_slw;
            end
            else
            begin
                yr = c_ext - half_slw;
            end
        end
        if (cfg.current_mode)
        begin
            fill_a = $signed(YW'(cfg.zero_row));
        end
        else
        begin
            fill_a = $signed(YW'(cfg.graph_height) << RFB);
        end
        if (cfg.thick_mode)
        begin
            ya = yl;
            yb = yr;
        end
        else
        begin
            ya = fill_a;
            yb = c_ext;
        end
        if (ya > yb)
        begin
            ya = yb;
            yb = cfg.thick_mode ? yl : fill_a;
        end
    end

    logic                  b3_valid_reg;
    logic signed [YW-1:0]  b3_ya_reg, b3_yb_reg;
    logic [COORD_BITS-1:0] b3_column_reg;
    logic                  b3_colour_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b3_ya_reg     <= ya;
            b3_yb_reg     <= yb;
            b3_column_reg <= b2_column_reg;
            b3_colour_reg <= b2_colour_reg;
        end
    end

    // ---------------- stage 4: pixel rounding and clipping ----------------
    logic signed [YW-1:0]       ya_up, neg_a;
    logic signed [YW:0]         span_len;
    logic signed [PIX_BITS-1:0] lo2, hi2, first, last, h_top;
    logic [PIX_BITS-1:0]        h_cap, h_lim;
    logic                       empty;

    always_comb
    begin
        ya_up    = b3_ya_reg + $signed(YW'((1 << RFB) - 1));
        neg_a    = -b3_ya_reg;
        lo2      = PIX_BITS'(ya_up >>> RFB);
        hi2      = PIX_BITS'(b3_yb_reg >>> RFB);
        span_len = $signed({b3_yb_reg[YW-1], b3_yb_reg}) - $signed({b3_ya_reg[YW-1], b3_ya_reg});
        if (lo2 > hi2)
        begin
            // both ends in one pixel: keep it if at least half covered
            if (span_len >= $signed((YW+1)'(1 << (RFB - 1))))
            begin
                first = hi2;
                last  = hi2;
            end
            else
            begin
                first = '0;
                last  = '1;
            end
        end
        else
        begin
            first = neg_a[RFB-1] ? lo2 - PIX_BITS'(1) : lo2;
            last  = b3_yb_reg[RFB-1] ? hi2 : hi2 - PIX_BITS'(1);
        end
        h_lim = PIX_BITS'(1) << COORD_BITS;
        h_cap = (PIX_BITS'(cfg.graph_height) > h_lim) ? h_lim : PIX_BITS'(cfg.graph_height);
        h_top = $signed(h_cap) - PIX_BITS'(1);
        if (first < 0)
        begin
            first = '0;
        end
        if (last > h_top)
        begin
            last = h_top;
        end
        empty = first > last;
    end

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_column_reg, out_low_reg, out_high_reg;
    logic                  out_colour_reg, out_empty_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_column_reg <= b3_column_reg;
            out_colour_reg <= b3_colour_reg;
            out_empty_reg  <= empty;
            out_low_reg    <= empty ? '0 : first[COORD_BITS-1:0];
            out_high_reg   <= empty ? '0 : last[COORD_BITS-1:0];
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= !q_empty;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg;
        end
    end

    assign spans.valid      = out_valid_reg;
    assign spans.column     = out_column_reg;
    assign spans.row_low    = out_low_reg;
    assign spans.row_high   = out_high_reg;
    assign spans.colour     = out_colour_reg;
    assign spans.span_empty = out_empty_reg;

endmodule

FILE: rtl/waveform_column_span_renderer.sv
// An accepted sample word passes the input register (row map, classify), the queue,
// three span stages and the output register to its span word; stalls can hold it.
// Throughput: one sample word per cycle unless the queue is full or spans are stalled;
// a word that primes or falls past the graph width gives no span and is never queued.
// Reset (rst_n low, asynchronous): window, counters, queue and all valids cleared;
// configuration registers return to their documented defaults.
module waveform_column_span_renderer #(
    parameter int ROW_FRACTION_BITS = 4,
    parameter int COORD_BITS        = 12,
    parameter int SAMPLE_BITS       = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [wcsr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wcsr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    wcsr_sample_if.sink                           samples,
    wcsr_span_if.source                           spans
);
    import wcsr_pkg::*;

    localparam int ROW_BITS = COORD_BITS + ROW_FRACTION_BITS + 2;
    localparam int JOB_BITS = 1 + COORD_BITS + 3 * ROW_BITS;

    // Configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width   <= RST_LINE_WIDTH;
            cfg_reg.thick_mode   <= RST_THICK_MODE;
            cfg_reg.current_mode <= RST_CURRENT_MODE;
            cfg_reg.level_gain   <= $signed(RST_LEVEL_GAIN);
            cfg_reg.zero_row     <= RST_ZERO_ROW;
            cfg_reg.graph_height <= RST_GRAPH_HEIGHT;
            cfg_reg.graph_width  <= RST_GRAPH_WIDTH;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LINE_WIDTH:   cfg_reg.line_width   <= cfg_data[7:0];
                REG_THICK_MODE:   cfg_reg.thick_mode   <= cfg_data[0];
                REG_CURRENT_MODE: cfg_reg.current_mode <= cfg_data[0];
                REG_LEVEL_GAIN:   cfg_reg.level_gain   <= $signed(cfg_data[15:0]);
                REG_ZERO_ROW:     cfg_reg.zero_row     <= cfg_data[15:0];
                REG_GRAPH_HEIGHT: cfg_reg.graph_height <= cfg_data[12:0];
                REG_GRAPH_WIDTH:  cfg_reg.graph_width  <= cfg_data[12:0];
                default:          ;
            endcase
        end
    end

    // Front: accept, map, classify
    logic                q_push, q_full, q_pop, q_empty;
    logic [JOB_BITS-1:0] q_wr_job, q_rd_job;

    wcsr_front #(
        .ROW_FRACTION_BITS (ROW_FRACTION_BITS),
        .COORD_BITS        (COORD_BITS),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .samples (samples),
        .q_push  (q_push),
        .q_job   (q_wr_job),
        .q_full  (q_full)
    );

    // Job queue between front and back
    wcsr_queue #(
        .WIDTH      (JOB_BITS),
        .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_job),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_job),
        .empty   (q_empty)
    );

    // Back: span geometry and output register
    wcsr_back #(
        .ROW_FRACTION_BITS (ROW_FRACTION_BITS),
        .COORD_BITS        (COORD_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_job   (q_rd_job),
        .q_pop   (q_pop),
        .spans   (spans)
    );

    // Front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    // Back never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    // Empty spans carry zero rows
    a_empty_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (spans.valid && spans.span_empty) |-> (spans.row_low == '0 && spans.row_high == '0))
        else $error("empty span with nonzero rows");

    // Drawn spans are ordered
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (spans.valid && !spans.span_empty) |-> (spans.row_low <= spans.row_high))
        else $error("span rows out of order");

endmodule

FILE: dv/waveform_column_span_renderer_tb.sv
`timescale 1ns / 100ps

module waveform_column_span_renderer_tb;

    import wcsr_pkg::*;

    localparam int ROW_FRAC       = 4;
    localparam int COORD          = 12;
    localparam int SAMPLE_W       = 16;
    localparam int MAX_ROWS       = 4096;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 50;
    localparam int DRAIN_PAUSE    = 20;
    localparam int HOLDOFF_PHASE  = 3;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] level;
        logic                       start_graph;
    } sample_word_t;

    typedef struct packed {
        logic [COORD-1:0] column;
        logic [COORD-1:0] row_low;
        logic [COORD-1:0] row_high;
        logic             colour;
        logic             span_empty;
    } span_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    wcsr_sample_if #(.SAMPLE_BITS(SAMPLE_W)) sample_bus ();
    wcsr_span_if   #(.COORD_BITS(COORD))     span_bus ();

    waveform_column_span_renderer #(
        .ROW_FRACTION_BITS (ROW_FRAC),
        .COORD_BITS        (COORD),
        .SAMPLE_BITS       (SAMPLE_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_bus),
        .spans     (span_bus)
    );

    // Register mirror and plot window of the predictor
    cfg_t        cfg;
    int          win_older_level;
    int          win_centre_level;
    longint      win_older_row;
    longint      win_centre_row;
    int unsigned col_count;
    int unsigned primed;

    sample_word_t sample_backlog[$];
    span_t        spans_due[$];

    int          words_queued;
    int          words_accepted;
    int          error_count;
    int          stall_count;
    bit          tx_steady;
    bit          rx_steady;
    int unsigned holdoff_left;

    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned rx_run;
    bit          rx_level;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Level to Q14.4 row, saturated to the 18-bit signed row range
    function automatic longint map_level_to_row(int level);
        longint r;
        r = longint'(cfg.zero_row) +
            ((longint'(level) * longint'($signed(cfg.level_gain))) >>>
             (GAIN_FRACTION_BITS - ROW_FRAC));
        if (r > (longint'(1) << 17) - 1)
            r = (longint'(1) << 17) - 1;
        if (r < -(longint'(1) << 17))
            r = -(longint'(1) << 17);
        return r;
    endfunction

    // Half line width towards a neighbour, widened by the slope
    function automatic longint thick_half_width(longint dy, longint lw);
        longint ady;
        longint hw;
        ady = (dy < 0) ? -dy : dy;
        if (ady < (longint'(SLOPE_LIMIT) << ROW_FRAC))
            hw = (lw * ((longint'(65536) << ROW_FRAC) + longint'(SQRT2M1_Q16) * ady)) >>>
                 (17 + ROW_FRAC);
        else
            hw = (ady + lw) >>> 1;
        return (dy < 0) ? -hw : hw;
    endfunction

    // Advance the plot window by one sample word; queue the span it yields
    function automatic void render_column(logic signed [SAMPLE_W-1:0] sample, logic restart);
        int          lvl;
        int unsigned cap;
        longint      row;
        longint      lw;
        longint      yl;
        longint      yr;
        longint      ya;
        longint      yb;
        longint      t;
        longint      lo;
        longint      hi;
        longint      first_row;
        longint      last_row;
        longint      ht;
        logic        col;
        span_t       s;

        lvl = int'(sample);
        if (restart)
        begin
            col_count = 0;
            primed    = 0;
        end
        cap = (cfg.graph_width > MAX_ROWS) ? MAX_ROWS : cfg.graph_width;
        row = map_level_to_row(lvl);

        if (primed < 2)
        begin
            win_older_level  = win_centre_level;
            win_older_row    = win_centre_row;
            win_centre_level = lvl;
            win_centre_row   = row;
            primed++;
            return;
        end
        if (col_count >= cap)
            return;

        if (cfg.current_mode)
            col = (win_centre_level > 0) ? 1'b0 : 1'b1;
        else
            col = (win_older_level < win_centre_level) ? 1'b0 : 1'b1;

        if (cfg.thick_mode)
        begin
            lw = (longint'(cfg.line_width) << ROW_FRAC) >>> 4;
            yl = win_centre_row - thick_half_width(win_centre_row - win_older_row, lw);
            yr = win_centre_row - thick_half_width(win_centre_row - row, lw);
            // peak or trough: the far side gets half a width beyond the centre
            if (win_centre_row > yl && win_centre_row > yr)
            begin
                if (yl > yr)
                    yl = win_centre_row + (lw >>> 1);
                else
                    yr = win_centre_row + (lw >>> 1);
            end
            else if (win_centre_row < yl && win_centre_row < yr)
            begin
                if (yl < yr)
                    yl = win_centre_row - (lw >>> 1);
                else
                    yr = win_centre_row - (lw >>> 1);
            end
            ya = yl;
            yb = yr;
        end
        else
        begin
            ya = cfg.current_mode ? longint'(cfg.zero_row)
                                  : (longint'(cfg.graph_height) << ROW_FRAC);
            yb = win_centre_row;
        end
        if (ya > yb)
        begin
            t  = ya;
            ya = yb;
            yb = t;
        end

        // whole pixels, plus partial end pixels covered at least half
        lo        = -((-ya) >>> ROW_FRAC);
        hi        = yb >>> ROW_FRAC;
        first_row = 0;
        last_row  = -1;
        if (lo > hi)
        begin
            if (yb - ya >= (longint'(1) << (ROW_FRAC - 1)))
            begin
                first_row = hi;
                last_row  = hi;
            end
        end
        else
        begin
            first_row = ((lo << ROW_FRAC) - ya >= (longint'(1) << (ROW_FRAC - 1))) ? lo - 1 : lo;
            last_row  = (yb - (hi << ROW_FRAC) >= (longint'(1) << (ROW_FRAC - 1))) ? hi : hi - 1;
        end

        ht = (cfg.graph_height > MAX_ROWS) ? longint'(MAX_ROWS) : longint'(cfg.graph_height);
        if (first_row < 0)
            first_row = 0;
        if (last_row > ht - 1)
            last_row = ht - 1;

        s.column     = col_count[COORD-1:0];
        s.span_empty = (first_row > last_row);
        s.row_low    = s.span_empty ? '0 : COORD'(first_row);
        s.row_high   = s.span_empty ? '0 : COORD'(last_row);
        s.colour     = col;
        spans_due    = {spans_due, s};

        win_older_level  = win_centre_level;
        win_older_row    = win_centre_row;
        win_centre_level = lvl;
        win_centre_row   = row;
        col_count++;
    endfunction

    function automatic int clamp_level(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    function automatic void compare_field(string name, logic [COORD-1:0] want,
                                          logic [COORD-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Register write, mirrored with the width of each register
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            REG_LINE_WIDTH:   cfg.line_width   = data[7:0];
            REG_THICK_MODE:   cfg.thick_mode   = data[0];
            REG_CURRENT_MODE: cfg.current_mode = data[0];
            REG_LEVEL_GAIN:   cfg.level_gain   = data;
            REG_ZERO_ROW:     cfg.zero_row     = data;
            REG_GRAPH_HEIGHT: cfg.graph_height = data[12:0];
            REG_GRAPH_WIDTH:  cfg.graph_width  = data[12:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Full register set; unused upper data bits carry junk
    task automatic program_regs(logic [7:0] lw, logic thick, logic cur, logic [15:0] gain,
                                logic [15:0] zero, logic [12:0] ht, logic [12:0] wd);
        write_reg(REG_LINE_WIDTH,   {8'($urandom), lw});
        write_reg(REG_THICK_MODE,   {15'($urandom), thick});
        write_reg(REG_CURRENT_MODE, {15'($urandom), cur});
        write_reg(REG_LEVEL_GAIN,   gain);
        write_reg(REG_ZERO_ROW,     zero);
        write_reg(REG_GRAPH_HEIGHT, {3'($urandom), ht});
        write_reg(REG_GRAPH_WIDTH,  {3'($urandom), wd});
        @(negedge clk);
    endtask

    task automatic queue_word(int level, bit start);
        sample_word_t w;
        w.level        = level[SAMPLE_W-1:0];
        w.start_graph  = start;
        sample_backlog = {sample_backlog, w};
        words_queued++;
    endtask

    // One graph: a start word, then a random walk around the graph middle
    task automatic queue_graph(int n);
        int     ht;
        int     gain;
        int     mid;
        int     amp;
        int     step;
        int     lvl;
        int     k;
        ht   = (cfg.graph_height == 0) ? 1 :
               ((cfg.graph_height > MAX_ROWS) ? MAX_ROWS : int'(cfg.graph_height));
        gain = int'($signed(cfg.level_gain));
        if (gain == 0)
        begin
            mid = 0;
            amp = 32767;
        end
        else
        begin
            mid = clamp_level(((longint'(ht) * 8 - longint'(cfg.zero_row)) * 16) / gain);
            amp = clamp_level((longint'(ht) * 128) / ((gain < 0) ? -gain : gain) + 4);
        end
        step = amp / 6 + 1;
        lvl  = mid;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 15))
                0, 1: lvl = clamp_level(longint'(mid) - amp + longint'($urandom_range(0, 2 * amp)));
                2: ;
                default: lvl = clamp_level(longint'(lvl) + longint'($urandom_range(0, 2 * step))
                                           - step);
            endcase
            queue_word(lvl, k == 0);
        end
    endtask

    task automatic queue_noise(int n);
        int k;
        for (k = 0; k < n; k++)
            queue_word(int'($urandom), $urandom_range(0, 5) == 0);
    endtask

    // Sender pauses until every span is back and the pipe is quiet
    task automatic wait_drained();
        while (words_accepted != words_queued || spans_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    // Sample driver: bursts of words from the backlog with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        sample_word_t w;
        if (!rst_n)
        begin
            sample_bus.valid        <= 1'b0;
            sample_bus.level_sample <= '0;
            sample_bus.start_graph  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (sample_bus.valid && sample_bus.ready)
            begin
                render_column(sample_bus.level_sample, sample_bus.start_graph);
                words_accepted++;
            end
            if (!sample_bus.valid || sample_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_bus.valid <= 1'b0;
                end
                else if (sample_backlog.size() > 0)
                begin
                    w = sample_backlog.pop_front();
                    sample_bus.valid        <= 1'b1;
                    sample_bus.level_sample <= w.level;
                    sample_bus.start_graph  <= w.start_graph;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = (tx_steady || $urandom_range(0, 3) == 0) ? 0
                                                                           : $urandom_range(1, 6);
                    end
                end
                else
                    sample_bus.valid <= 1'b0;
            end
        end
    end

    // Span receiver: long hold-off on request, else alternating ready/stall runs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_bus.ready <= 1'b0;
            rx_run   = 0;
            rx_level = 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left--;
            span_bus.ready <= 1'b0;
        end
        else if (rx_steady)
            span_bus.ready <= 1'b1;
        else
        begin
            if (rx_run == 0)
            begin
                rx_level = !rx_level;
                rx_run   = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            rx_run--;
            span_bus.ready <= rx_level;
        end
    end

    // Span checker
    always @(posedge clk)
    begin
        span_t due;
        if (rst_n && span_bus.valid && span_bus.ready)
        begin
            if (spans_due.size() == 0)
            begin
                $error("span word at column %0d with none expected", span_bus.column);
                error_count++;
            end
            else
            begin
                due = spans_due.pop_front();
                compare_field("column",     due.column,     span_bus.column);
                compare_field("row_low",    due.row_low,    span_bus.row_low);
                compare_field("row_high",   due.row_high,   span_bus.row_high);
                compare_field("colour",     COORD'(due.colour),     COORD'(span_bus.colour));
                compare_field("span_empty", COORD'(due.span_empty), COORD'(span_bus.span_empty));
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_bus.valid && sample_bus.ready) || (span_bus.valid && span_bus.ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= WATCHDOG_LIMIT)
            begin
                $display("waveform_column_span_renderer_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        int queued;
        int n;

        rst_n                   = 1'b0;
        cfg_write               = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        sample_bus.valid        = 1'b0;
        sample_bus.level_sample = '0;
        sample_bus.start_graph  = 1'b0;
        span_bus.ready          = 1'b0;
        tx_steady               = 1'b0;
        rx_steady               = 1'b0;
        holdoff_left            = 0;
        words_queued            = 0;
        words_accepted          = 0;
        error_count             = 0;
        stall_count             = 0;

        cfg.line_width   = RST_LINE_WIDTH;
        cfg.thick_mode   = RST_THICK_MODE;
        cfg.current_mode = RST_CURRENT_MODE;
        cfg.level_gain   = RST_LEVEL_GAIN;
        cfg.zero_row     = RST_ZERO_ROW;
        cfg.graph_height = RST_GRAPH_HEIGHT;
        cfg.graph_width  = RST_GRAPH_WIDTH;
        win_older_level  = 0;
        win_centre_level = 0;
        win_older_row    = 0;
        win_centre_row   = 0;
        col_count        = 0;
        primed           = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at reset settings: row = 2048 - level
        queue_word(0, 1);          // primers
        queue_word(0, 0);
        queue_word(32767, 0);      // row saturates low
        queue_word(-32768, 0);     // row saturates high
        queue_word(-1, 0);
        queue_word(1800, 1);       // restart mid graph
        queue_word(1800, 0);
        queue_word(1800, 0);       // flat line
        queue_word(1810, 0);
        queue_word(1790, 0);       // peak
        queue_word(1810, 0);       // trough
        queue_word(1811, 0);       // gentle slope
        queue_word(1812, 0);
        queue_word(1900, 0);       // steep up
        queue_word(1700, 0);       // steep down
        queue_word(1700, 0);
        queue_word(2048, 0);       // top row
        queue_word(2049, 0);       // above the graph
        queue_word(1569, 0);       // bottom row
        queue_word(1568, 0);       // below the graph
        queue_word(1569, 0);
        queue_word(0, 0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0: program_regs(16, 1, 0, -256, 3840, 480, 640);
                1: program_regs(0, 1, 1, -256, 2000, 300, 4096);
                2: program_regs(255, 1, 0, -1000, 4000, 480, 200);
                3: program_regs(40, 0, 0, -300, 4000, 480, 640);
                4: program_regs(8'($urandom), 0, 1, 512, 2000, 256, 7);
                5: program_regs(8'($urandom), 1, 1'($urandom), -32768, 65535, 4096, 1);
                6: program_regs(8'($urandom), 1'($urandom), 1'($urandom), 32767, 0, 1, 4096);
                7: program_regs(8'($urandom), 1, 0, 0, 16'($urandom), 0, 5);
                8: program_regs(255, 1, 1, -77, 30000, 8191, 8191);
                9: program_regs(8'($urandom), 0, 0, -256, 3840, 480, 0);
                default: program_regs(8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
                                      16'($urandom), 13'($urandom_range(1, 4096)),
                                      13'($urandom_range(1, 64)));
            endcase

            // no idling at all in some phases, random idling on either side in others
            tx_steady = (phase % 4 == 0) || ($urandom_range(0, 2) == 0);
            rx_steady = (phase % 4 == 0) || ($urandom_range(0, 2) == 0);
            if (phase == HOLDOFF_PHASE)
            begin
                tx_steady    = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end

            queued = 0;
            while (queued < PHASE_WORDS)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    n = $urandom_range(3, 24);
                    queue_graph(n);
                end
                else
                begin
                    n = $urandom_range(1, 8);
                    queue_noise(n);
                end
                queued += n;
            end
        end

        wait_drained();
        if (error_count == 0)
            $display("waveform_column_span_renderer_tb: clean");
        else
            $display("waveform_column_span_renderer_tb: errors");
        $finish;
    end

endmodule
